// File: rtl/efmd_pkg.sv
package efmd_pkg;

  localparam int unsigned MinSchemaReset = 32'd1;
  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] ChPipe = 8'h7c;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChPlus = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;

  localparam logic [3:0] FieldsCompact = 4'd8;
  localparam logic [3:0] FieldsFull = 4'd11;
  localparam logic [3:0] FieldMax = 4'd15;

  typedef enum logic [1:0] {
    NUM_SPACE  = 2'd0,
    NUM_SIGN   = 2'd1,
    NUM_DIGITS = 2'd2,
    NUM_DONE   = 2'd3
  } num_phase_t;

  typedef enum logic [1:0] {
    OP_TEXT  = 2'd0,
    OP_NUM   = 2'd1,
    OP_KW    = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // one classified transaction handed from front to back
  typedef struct packed {
    op_t        op;
    logic       sep;        // unescaped separator
    logic       emit;       // text byte is emitted
    logic       tail_bs;    // lone trailing backslash to emit at end
    logic [3:0] field;
    logic [7:0] data;
    logic       eom;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  pos;
    logic [7:0]  data;
    logic        status;
    logic        compact;
    logic [31:0] schema;
    logic [1:0]  chan;
    logic        qos;
    logic [63:0] seq;
    logic [63:0] ts;
    logic [31:0] ttl;
  } result_t;

  // keyword characters, position 0..12; keyword k
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] p);
    logic [8*13-1:0] s;
    logic [3:0] len;
    begin
      case (k)
        3'd0: begin s = {"control", 48'd0}; len = 4'd7; end
        3'd1: begin s = {"telemetry", 32'd0}; len = 4'd9; end
        3'd2: begin s = {"event", 64'd0}; len = 4'd5; end
        3'd3: begin s = {"best_", "effort", 16'd0}; len = 4'd11; end
        default: begin s = {"at_least_", "once"}; len = 4'd13; end
      endcase
      if (p >= len) kw_char = 8'd0;
      else kw_char = s[8*(12 - 32'(p)) +: 8];
    end
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] k);
    case (k)
      3'd0: kw_len = 4'd7;
      3'd1: kw_len = 4'd9;
      3'd2: kw_len = 4'd5;
      3'd3: kw_len = 4'd11;
      default: kw_len = 4'd13;
    endcase
  endfunction

  function automatic logic is_num_field(input logic [3:0] f);
    is_num_field = (f == 4'd0) || (f == 4'd3) || (f == 4'd4) || (f == 4'd5);
  endfunction

  function automatic logic is_text_field(input logic [3:0] f);
    is_text_field = (f >= 4'd6) && (f <= 4'd10);
  endfunction

endpackage

// File: rtl/efmd_front.sv
module efmd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              end_of_message,
  input  logic              take,
  output efmd_pkg::cmd_t    cmd
);
  import efmd_pkg::*;

  logic [3:0] field_index, field_index_next;
  logic       parity, parity_next;
  logic       is_sep;
  logic       end_parity;

  // escape tracking and field counting
  always_comb begin
    is_sep = (in_byte == ChPipe) && !parity;
    parity_next = parity;
    field_index_next = field_index;
    end_parity = parity;
    if (is_sep) begin
      parity_next = 1'b0;
      if (field_index != FieldMax) field_index_next = field_index + 4'd1;
    end else begin
      parity_next = (in_byte == ChBslash) ? !parity : 1'b0;
    end
    end_parity = parity_next;
    if (end_of_message) begin
      field_index_next = '0;
      parity_next = 1'b0;
    end
  end

  always_comb begin
    cmd.sep = is_sep;
    cmd.field = field_index;
    cmd.data = in_byte;
    cmd.eom = end_of_message;
    if (is_text_field(field_index)) cmd.op = OP_TEXT;
    else if (is_num_field(field_index)) cmd.op = OP_NUM;
    else if (field_index == 4'd1 || field_index == 4'd2) cmd.op = OP_KW;
    else cmd.op = OP_NONE;
    cmd.emit = !is_sep && is_text_field(field_index) &&
               !(in_byte == ChBslash && !parity);
    cmd.tail_bs = end_of_message && end_parity &&
                  is_text_field(is_sep ? field_index + 4'd1 : field_index);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index <= '0;
      parity <= 1'b0;
    end else if (in_valid && take) begin
      field_index <= field_index_next;
      parity <= parity_next;
    end
  end

endmodule

// File: rtl/efmd_queue.sv
module efmd_queue #(
  parameter int unsigned Depth = efmd_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  efmd_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output efmd_pkg::cmd_t pop_data
);
  import efmd_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t entries [Depth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full = (count == (AW+1)'(Depth));
  assign not_empty = (count != '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full)
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop && not_empty)
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && not_empty);
    end
  end

endmodule

// File: rtl/efmd_back.sv
module efmd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       min_schema,
  input  logic              cmd_valid,
  input  efmd_pkg::cmd_t    cmd,
  output logic              cmd_take,
  output logic              out_valid,
  input  logic              out_stall,
  output efmd_pkg::result_t out_data
);
  import efmd_pkg::*;

  num_phase_t  phase, phase_next;
  logic        neg, neg_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  kw_pos, kw_pos_next;
  logic [2:0]  cand, cand_next;
  logic [31:0] cap_schema, cap_schema_next;
  logic [63:0] cap_seq, cap_seq_next;
  logic [63:0] cap_ts, cap_ts_next;
  logic [31:0] cap_ttl, cap_ttl_next;
  logic [1:0]  cap_chan, cap_chan_next;
  logic        cap_qos, cap_qos_next;
  logic        err, err_next;
  logic [3:0]  fcount, fcount_next;

  // output: an output slot and a slot for the waiting summary; a transaction may make both
  result_t slot_a, slot_b;
  logic    a_valid, b_valid;
  logic    pend;      // second result of the transaction waits behind the first
  result_t pend_data;

  logic       is_ws, is_dig, ovf;
  logic [3:0] dig;
  logic [63:0] acc_x10, signed_val;
  logic [3:0]  cur_field;
  logic        fin;
  logic        kw_hit;
  logic [1:0]  kw_which;
  logic [2:0]  base;
  logic        make_text, make_sum;
  result_t     text_res, sum_res;
  logic        valid_msg;
  logic [3:0]  end_count;

  // accept a transaction only when no second result waits and the output slot is empty or being taken
  assign out_valid = a_valid;
  assign out_data = slot_a;
  assign cmd_take = !pend && (!a_valid || !out_stall);

  always_comb begin
    is_ws = (cmd.data == 8'd32) || (cmd.data >= 8'd9 && cmd.data <= 8'd13);
    is_dig = (cmd.data >= 8'd48) && (cmd.data <= 8'd57);
    dig = cmd.data[3:0];
    acc_x10 = {acc[60:0], 3'b000} + {acc[62:0], 1'b0};
    // overflow when acc > (2^64-1-d)/10
    ovf = (acc > 64'd1844674407370955161) ||
          ((acc == 64'd1844674407370955161) && (dig > 4'd5));

    phase_next = phase; neg_next = neg; acc_next = acc;
    kw_pos_next = kw_pos; cand_next = cand;
    cap_schema_next = cap_schema; cap_seq_next = cap_seq;
    cap_ts_next = cap_ts; cap_ttl_next = cap_ttl;
    cap_chan_next = cap_chan; cap_qos_next = cap_qos;
    err_next = err; fcount_next = fcount;
    base = (cmd.field == 4'd1) ? 3'd0 : 3'd3;

    if (!cmd.sep) begin
      if (cmd.op == OP_NUM) begin
        case (phase)
          NUM_SPACE: begin
            if (!is_ws) begin
              if (cmd.data == ChPlus || cmd.data == ChMinus) begin
                neg_next = (cmd.data == ChMinus);
                phase_next = NUM_SIGN;
              end else if (is_dig) begin
                acc_next = {60'd0, dig};
                phase_next = NUM_DIGITS;
              end else begin
                err_next = 1'b1;
                phase_next = NUM_DONE;
              end
            end
          end
          NUM_SIGN: begin
            if (is_dig) begin
              acc_next = {60'd0, dig};
              phase_next = NUM_DIGITS;
            end else begin
              err_next = 1'b1;
              phase_next = NUM_DONE;
            end
          end
          NUM_DIGITS: begin
            if (!is_dig) phase_next = NUM_DONE;
            else if (ovf) begin
              err_next = 1'b1;
              phase_next = NUM_DONE;
            end else acc_next = acc_x10 + {60'd0, dig};
          end
          default: ;
        endcase
      end else if (cmd.op == OP_KW) begin
        for (int i = 0; i < 3; i++) begin
          if ((i < 2 || cmd.field == 4'd1) &&
              (kw_pos >= kw_len(base + 3'(i)) || kw_char(base + 3'(i), kw_pos) != cmd.data))
            cand_next[i] = 1'b0;
        end
        if (cmd.field == 4'd2) cand_next[2] = 1'b0;
        if (kw_pos != FieldMax) kw_pos_next = kw_pos + 4'd1;
      end
    end

    // field close: separator, end of message, or both (separator then empty field)
    fin = cmd.sep || cmd.eom;
    cur_field = cmd.field;
    kw_hit = 1'b0;
    kw_which = 2'd0;
    signed_val = neg_next ? (64'd0 - acc_next) : acc_next;
    for (int i = 2; i >= 0; i--) begin
      if (cand_next[i] && kw_len(base + 3'(i)) == kw_pos_next &&
          (i < 2 || cmd.field == 4'd1)) begin
        kw_hit = 1'b1;
        kw_which = 2'(i);
      end
    end
    if (cmd.sep || cmd.eom) begin
      if (is_num_field(cur_field)) begin
        if (phase_next == NUM_SPACE || phase_next == NUM_SIGN) err_next = 1'b1;
        else if (cur_field == 4'd0) cap_schema_next = signed_val[31:0];
        else if (cur_field == 4'd3) cap_seq_next = signed_val;
        else if (cur_field == 4'd4) cap_ts_next = signed_val;
        else cap_ttl_next = signed_val[31:0];
      end else if (cur_field == 4'd1) begin
        if (kw_hit) cap_chan_next = kw_which;
        else err_next = 1'b1;
      end else if (cur_field == 4'd2) begin
        if (kw_hit) cap_qos_next = kw_which[0];
        else err_next = 1'b1;
      end
      if (fcount != FieldMax) fcount_next = fcount + 4'd1;
      phase_next = NUM_SPACE; neg_next = 1'b0; acc_next = '0;
      kw_pos_next = '0; cand_next = 3'b111;
    end
    end_count = fcount_next;
    // separator then end: the new empty field closes too
    if (cmd.sep && cmd.eom) begin
      if (is_num_field(cur_field + 4'd1)) err_next = 1'b1;
      else if (cur_field + 4'd1 == 4'd1 || cur_field + 4'd1 == 4'd2) err_next = 1'b1;
      if (fcount_next != FieldMax) end_count = fcount_next + 4'd1;
    end
    if (!fin) end_count = fcount;

    valid_msg = (end_count == FieldsCompact || end_count == FieldsFull) && !err_next &&
                (cap_schema_next >= min_schema);

    text_res = '0;
    text_res.pos = cmd.emit ? cmd.field : (cmd.sep ? cmd.field + 4'd1 : cmd.field);
    text_res.data = cmd.emit ? cmd.data : ChBslash;
    make_text = cmd.emit || cmd.tail_bs;

    sum_res = '0;
    sum_res.kind = 1'b1;
    sum_res.status = !valid_msg;
    if (valid_msg) begin
      sum_res.compact = (end_count == FieldsCompact);
      sum_res.schema = cap_schema_next;
      sum_res.chan = cap_chan_next;
      sum_res.qos = cap_qos_next;
      sum_res.seq = cap_seq_next;
      sum_res.ts = cap_ts_next;
      sum_res.ttl = cap_ttl_next;
    end
    make_sum = cmd.eom;

    if (cmd.eom) begin
      fcount_next = '0; err_next = 1'b0;
      cap_schema_next = '0; cap_seq_next = '0; cap_ts_next = '0;
      cap_ttl_next = '0; cap_chan_next = '0; cap_qos_next = 1'b0;
    end
  end

  // slot_b unused beyond holding the second result
  assign slot_b = pend_data;
  assign b_valid = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= NUM_SPACE; neg <= 1'b0; acc <= '0;
      kw_pos <= '0; cand <= 3'b111;
      cap_schema <= '0; cap_seq <= '0; cap_ts <= '0; cap_ttl <= '0;
      cap_chan <= '0; cap_qos <= 1'b0; err <= 1'b0; fcount <= '0;
      a_valid <= 1'b0; pend <= 1'b0;
    end else begin
      if (cmd_valid && cmd_take) begin
        phase <= phase_next; neg <= neg_next; acc <= acc_next;
        kw_pos <= kw_pos_next; cand <= cand_next;
        cap_schema <= cap_schema_next; cap_seq <= cap_seq_next;
        cap_ts <= cap_ts_next; cap_ttl <= cap_ttl_next;
        cap_chan <= cap_chan_next; cap_qos <= cap_qos_next;
        err <= err_next; fcount <= fcount_next;
        a_valid <= make_text || make_sum;
        pend <= make_text && make_sum;
      end else if (a_valid && !out_stall) begin
        a_valid <= b_valid;
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_take) begin
      slot_a <= make_text ? text_res : sum_res;
      pend_data <= sum_res;
    end else if (a_valid && !out_stall && b_valid) begin
      slot_a <= slot_b;
    end
  end

endmodule

// File: rtl/escaped_field_message_decoder.sv
// Decodes '|'-separated messages one byte per cycle while the queue is not
// full. A front stage tracks escapes and field boundaries, a four-entry queue
// decouples it from the back stage that parses numbers and keywords and builds
// results. A byte yields at most one result per cycle; a final byte that
// yields both a text byte (an emitted byte or a trailing backslash) and the
// summary holds the back stage until the summary moves to the output slot. A
// taken byte passes the queue register and the output register of the back
// stage; a summary behind such a text byte follows once the text byte leaves.
module escaped_field_message_decoder #(
  parameter int unsigned QDepth = efmd_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        item_kind,
  output logic [3:0]  field_position,
  output logic [7:0]  text_byte,
  output logic        status,
  output logic        compact_form,
  output logic [31:0] schema_ver,
  output logic [1:0]  channel_kind,
  output logic        delivery_qos,
  output logic [63:0] sequence_number,
  output logic [63:0] stamp_ms,
  output logic [31:0] ttl_ms
);
  import efmd_pkg::*;

  logic [31:0] min_schema_reg;
  cmd_t    fcmd, qcmd;
  logic    q_full, q_ne, b_take;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) min_schema_reg <= MinSchemaReset;
    else if (cfg_we) min_schema_reg <= cfg_data;
  end

  assign in_stall = q_full;

  efmd_front u_front (
    .clk, .rst, .in_valid, .in_byte, .end_of_message,
    .take(!q_full), .cmd(fcmd)
  );

  efmd_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst, .push(in_valid), .push_data(fcmd), .full(q_full),
    .pop(b_take), .not_empty(q_ne), .pop_data(qcmd)
  );

  efmd_back u_back (
    .clk, .rst, .min_schema(min_schema_reg), .cmd_valid(q_ne), .cmd(qcmd),
    .cmd_take(b_take), .out_valid, .out_stall, .out_data(res)
  );

  assign item_kind = res.kind;
  assign field_position = res.pos;
  assign text_byte = res.data;
  assign status = res.status;
  assign compact_form = res.compact;
  assign schema_ver = res.schema;
  assign channel_kind = res.chan;
  assign delivery_qos = res.qos;
  assign sequence_number = res.seq;
  assign stamp_ms = res.ts;
  assign ttl_ms = res.ttl;

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_full) else $error("stall without full queue");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_summary_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind && status |-> ttl_ms == '0 && schema_ver == '0)
    else $error("invalid summary carries values");

endmodule
